@@ rtl/core/adc_pingpong_packetizer_defines.svh @@
// Assertion macros shared by the packetizer RTL.
// Both forms clock on the rising edge and are disabled while reset is low.
`ifndef ADC_PINGPONG_PACKETIZER_DEFINES_SVH
`define ADC_PINGPONG_PACKETIZER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ADCPP_ASSERT_IMPLY(LBL, CLK, RSTN, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!(RSTN)) (ANTE) |-> (CONS)) \
    else $error("adcpp assertion failed");
// Next-cycle implication.
`define ADCPP_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!(RSTN)) (ANTE) |=> (CONS)) \
    else $error("adcpp assertion failed");
`else
`define ADCPP_ASSERT_IMPLY(LBL, CLK, RSTN, ANTE, CONS)
`define ADCPP_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS)
`endif
`endif

@@ rtl/core/adcpp_pkg.sv @@
`timescale 1ns / 1ps
package adcpp_pkg;

  // Input request codes.
  localparam logic [1:0] FUNC_POLL  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_STOP  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_LED    = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_INTERVAL = 2'd0;
  localparam logic [1:0] REG_CHAN2    = 2'd1;
  localparam logic [1:0] REG_MODE     = 2'd2;

  localparam logic [11:0] LED_THRESHOLD = 12'd2048;
  localparam int          HDR_BYTES     = 4;

  // Work decided at accept time for one poll.
  typedef struct packed {
    logic [1:0]  send_en;
    logic [15:0] seq;
    logic [1:0]  mask0;
    logic [1:0]  mask1;
    logic [7:0]  mode0;
    logic [7:0]  mode1;
    logic [1:0]  wr_en;
    logic [11:0] wr_data0;
    logic [11:0] wr_data1;
    logic        led;
  } plan_t;

  // One result record.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] seq;
    logic [1:0]  mask;
    logic [7:0]  mode;
    logic [6:0]  len;
    logic [11:0] sample;
    logic        last;
  } res_t;

endpackage

@@ rtl/core/adcpp_ram.sv @@
`timescale 1ns / 1ps
module adcpp_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/adcpp_ctrl.sv @@
`timescale 1ns / 1ps
module adcpp_ctrl #(
  parameter int BATCH_SAMPLES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_fire,
  input  logic [1:0]                           func,
  input  logic [31:0]                          now_cycles,
  input  logic [1:0]                           conversions_done,
  input  logic [11:0]                          sample_first,
  input  logic [11:0]                          sample_second,
  input  logic [1:0]                           send_accept,
  input  logic [31:0]                          interval_cycles,
  input  logic                                 second_channel_enable,
  input  logic [7:0]                           frame_mode,
  output adcpp_pkg::plan_t                     plan,
  output logic                                 plan_valid,
  output logic [$clog2(2*BATCH_SAMPLES)-1:0]   plan_waddr0,
  output logic [$clog2(2*BATCH_SAMPLES)-1:0]   plan_waddr1
);
  import adcpp_pkg::*;

  localparam int AW   = $clog2(2*BATCH_SAMPLES);
  localparam int WI_W = $clog2(BATCH_SAMPLES+1);
  localparam logic [WI_W-1:0] BATCH_W = WI_W'(BATCH_SAMPLES);
  localparam logic [AW-1:0]   BASE1   = AW'(BATCH_SAMPLES);

  logic            running_r, running_nxt;
  logic            first_pend_r, first_pend_nxt;
  logic [31:0]     last_t_r, last_t_nxt;
  logic            active_r, active_nxt;
  logic [WI_W-1:0] wi_r, wi_nxt;
  logic [1:0]      pend_r, pend_nxt;
  logic [1:0]      pmask_r [2];
  logic [1:0]      pmask_nxt [2];
  logic [7:0]      pmode_r [2];
  logic [7:0]      pmode_nxt [2];
  logic [15:0]     seq_r, seq_nxt;
  logic [11:0]     led_ref_r, led_ref_nxt;
  logic [11:0]     last_smp_r, last_smp_nxt;
  plan_t           plan_r, plan_nxt;
  logic            plan_valid_r, plan_valid_nxt;
  logic [AW-1:0]   waddr0_r, waddr0_nxt, waddr1_r, waddr1_nxt;

  logic            rate_on, early, done_any, done_two, w0, w1, proceed, led_hit, full;
  logic [1:0]      send_en;
  logic [WI_W-1:0] wi1, wi2;
  logic [11:0]     latest;
  logic [AW-1:0]   addr0, addr1;

  assign rate_on  = |interval_cycles;
  // wrapping difference against the last sampling time
  assign early    = rate_on && !first_pend_r && ((now_cycles - last_t_r) < interval_cycles);
  assign send_en  = pend_r & send_accept;
  assign done_any = |conversions_done;
  assign done_two = conversions_done[1];
  assign w0       = done_any && (wi_r < BATCH_W);
  assign wi1      = wi_r + WI_W'(w0);
  assign w1       = second_channel_enable && done_two && (wi1 < BATCH_W);
  assign wi2      = wi1 + WI_W'(w1);
  assign proceed  = done_any && (!second_channel_enable || done_two);
  assign latest   = w1 ? sample_second : (w0 ? sample_first : last_smp_r);
  assign led_hit  = (latest > LED_THRESHOLD) != (led_ref_r > LED_THRESHOLD);
  assign full     = wi2 >= BATCH_W;
  assign addr0    = active_r ? BASE1 + AW'(wi_r) : AW'(wi_r);
  assign addr1    = active_r ? BASE1 + AW'(wi1) : AW'(wi1);

  always_comb begin
    running_nxt    = running_r;
    first_pend_nxt = first_pend_r;
    last_t_nxt     = last_t_r;
    active_nxt     = active_r;
    wi_nxt         = wi_r;
    pend_nxt       = pend_r;
    pmask_nxt      = pmask_r;
    pmode_nxt      = pmode_r;
    seq_nxt        = seq_r;
    led_ref_nxt    = led_ref_r;
    last_smp_nxt   = last_smp_r;
    plan_nxt       = plan_r;
    plan_valid_nxt = 1'b0;
    waddr0_nxt     = waddr0_r;
    waddr1_nxt     = waddr1_r;
    if (in_fire) begin
      case (func)
        FUNC_START: begin
          if (!running_r) begin
            seq_nxt        = '0;
            active_nxt     = 1'b0;
            wi_nxt         = '0;
            pend_nxt       = '0;
            first_pend_nxt = 1'b1;
            running_nxt    = 1'b1;
          end
        end
        FUNC_STOP: begin
          running_nxt = 1'b0;
        end
        FUNC_POLL: begin
          if (running_r) begin
            plan_valid_nxt    = 1'b1;
            plan_nxt.send_en  = send_en;
            plan_nxt.seq      = seq_r;
            plan_nxt.mask0    = pmask_r[0];
            plan_nxt.mask1    = pmask_r[1];
            plan_nxt.mode0    = pmode_r[0];
            plan_nxt.mode1    = pmode_r[1];
            plan_nxt.wr_en    = '0;
            plan_nxt.wr_data0 = sample_first;
            plan_nxt.wr_data1 = sample_second;
            plan_nxt.led      = 1'b0;
            seq_nxt  = seq_r + 16'(send_en[0]) + 16'(send_en[1]);
            pend_nxt = pend_r & ~send_en;
            if (rate_on && !early) begin
              first_pend_nxt = 1'b0;
              last_t_nxt     = now_cycles;
            end
            if (!early) begin
              plan_nxt.wr_en = {w1, w0};
              waddr0_nxt     = addr0;
              waddr1_nxt     = addr1;
              wi_nxt         = wi2;
              if (w1) begin
                last_smp_nxt = sample_second;
              end else if (w0) begin
                last_smp_nxt = sample_first;
              end
              if (proceed) begin
                plan_nxt.led = led_hit;
                if (led_hit) begin
                  led_ref_nxt = latest;
                end
                // mark the filled buffer and swap, even onto a pending one
                if (full) begin
                  pmask_nxt[active_r] = {second_channel_enable, 1'b1};
                  pmode_nxt[active_r] = frame_mode;
                  pend_nxt[active_r]  = 1'b1;
                  active_nxt          = ~active_r;
                  wi_nxt              = '0;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r    <= 1'b0;
      first_pend_r <= 1'b1;
      last_t_r     <= '0;
      active_r     <= 1'b0;
      wi_r         <= '0;
      pend_r       <= '0;
      pmask_r[0]   <= '0;
      pmask_r[1]   <= '0;
      pmode_r[0]   <= '0;
      pmode_r[1]   <= '0;
      seq_r        <= '0;
      led_ref_r    <= '0;
      plan_valid_r <= 1'b0;
    end else begin
      running_r    <= running_nxt;
      first_pend_r <= first_pend_nxt;
      last_t_r     <= last_t_nxt;
      active_r     <= active_nxt;
      wi_r         <= wi_nxt;
      pend_r       <= pend_nxt;
      pmask_r      <= pmask_nxt;
      pmode_r      <= pmode_nxt;
      seq_r        <= seq_nxt;
      led_ref_r    <= led_ref_nxt;
      plan_valid_r <= plan_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_smp_r <= last_smp_nxt;
    plan_r     <= plan_nxt;
    waddr0_r   <= waddr0_nxt;
    waddr1_r   <= waddr1_nxt;
  end

  assign plan        = plan_r;
  assign plan_valid  = plan_valid_r;
  assign plan_waddr0 = waddr0_r;
  assign plan_waddr1 = waddr1_r;

endmodule

@@ rtl/core/adcpp_emit.sv @@
`timescale 1ns / 1ps
`include "adc_pingpong_packetizer_defines.svh"
module adcpp_emit #(
  parameter int BATCH_SAMPLES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               plan_valid,
  input  adcpp_pkg::plan_t                   plan,
  input  logic [$clog2(2*BATCH_SAMPLES)-1:0] plan_waddr0,
  input  logic [$clog2(2*BATCH_SAMPLES)-1:0] plan_waddr1,
  output logic                               ram_we,
  output logic [$clog2(2*BATCH_SAMPLES)-1:0] ram_waddr,
  output logic [11:0]                        ram_wdata,
  output logic                               ram_re,
  output logic [$clog2(2*BATCH_SAMPLES)-1:0] ram_raddr,
  input  logic [11:0]                        ram_rdata,
  output adcpp_pkg::res_t                    res,
  output logic                               res_valid,
  input  logic                               res_ready,
  output logic                               busy
);
  import adcpp_pkg::*;

  localparam int AW   = $clog2(2*BATCH_SAMPLES);
  localparam int WI_W = $clog2(BATCH_SAMPLES+1);
  localparam logic [WI_W-1:0] BATCH_W = WI_W'(BATCH_SAMPLES);
  localparam logic [WI_W-1:0] LAST_W  = WI_W'(BATCH_SAMPLES-1);
  localparam logic [AW-1:0]   BASE1   = AW'(BATCH_SAMPLES);
  localparam logic [6:0]      LEN     = 7'(HDR_BYTES + 2*BATCH_SAMPLES);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HDR  = 3'd1;
  localparam logic [2:0] ST_DATA = 3'd2;
  localparam logic [2:0] ST_WR   = 3'd3;
  localparam logic [2:0] ST_LED  = 3'd4;

  logic [2:0]      state_r, state_nxt;
  plan_t           plan_r, plan_nxt;
  logic [AW-1:0]   waddr0_r, waddr0_nxt, waddr1_r, waddr1_nxt;
  logic            buf_r, buf_nxt;
  logic [15:0]     seq_r, seq_nxt;
  logic [WI_W-1:0] rd_idx_r, rd_idx_nxt, emit_idx_r, emit_idx_nxt;
  logic            pend_r, pend_nxt;
  logic            out_valid_r, out_valid_nxt;
  res_t            res_r, res_nxt;

  logic            out_free, res_load, tail_last;
  logic [1:0]      hdr_mask;
  logic [7:0]      hdr_mode;
  logic [2:0]      after_wr;

  assign out_free  = !out_valid_r || res_ready;
  assign hdr_mask  = buf_r ? plan_r.mask1 : plan_r.mask0;
  assign hdr_mode  = buf_r ? plan_r.mode1 : plan_r.mode0;
  assign tail_last = (buf_r || !plan_r.send_en[1]) && !plan_r.led;
  assign after_wr  = plan_r.led ? ST_LED : ST_IDLE;
  assign ram_raddr = buf_r ? BASE1 + AW'(rd_idx_r) : AW'(rd_idx_r);

  always_comb begin
    state_nxt    = state_r;
    plan_nxt     = plan_r;
    waddr0_nxt   = waddr0_r;
    waddr1_nxt   = waddr1_r;
    buf_nxt      = buf_r;
    seq_nxt      = seq_r;
    rd_idx_nxt   = rd_idx_r;
    emit_idx_nxt = emit_idx_r;
    res_nxt      = res_r;
    res_load     = 1'b0;
    ram_re       = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = waddr0_r;
    ram_wdata    = plan_r.wr_data0;
    case (state_r)
      ST_IDLE: begin
        if (plan_valid) begin
          plan_nxt   = plan;
          waddr0_nxt = plan_waddr0;
          waddr1_nxt = plan_waddr1;
          seq_nxt    = plan.seq;
          if (plan.send_en[0]) begin
            buf_nxt   = 1'b0;
            state_nxt = ST_HDR;
          end else if (plan.send_en[1]) begin
            buf_nxt   = 1'b1;
            state_nxt = ST_HDR;
          end else begin
            state_nxt = ST_WR;
          end
        end
      end
      ST_HDR: begin
        if (out_free) begin
          res_load       = 1'b1;
          res_nxt.kind   = KIND_HEADER;
          res_nxt.seq    = seq_r;
          res_nxt.mask   = hdr_mask;
          res_nxt.mode   = hdr_mode;
          res_nxt.len    = LEN;
          res_nxt.sample = '0;
          res_nxt.last   = 1'b0;
          rd_idx_nxt     = '0;
          emit_idx_nxt   = '0;
          state_nxt      = ST_DATA;
        end
      end
      ST_DATA: begin
        // stream reads: keep at most one word in the RAM output register
        ram_re = (rd_idx_r < BATCH_W) && (!pend_r || out_free);
        if (ram_re) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (pend_r && out_free) begin
          res_load       = 1'b1;
          res_nxt.kind   = KIND_SAMPLE;
          res_nxt.seq    = seq_r;
          res_nxt.mask   = hdr_mask;
          res_nxt.mode   = hdr_mode;
          res_nxt.len    = LEN;
          res_nxt.sample = ram_rdata;
          res_nxt.last   = (emit_idx_r == LAST_W) && tail_last;
          emit_idx_nxt   = emit_idx_r + 1'b1;
          if (emit_idx_r == LAST_W) begin
            seq_nxt = seq_r + 16'd1;
            if (!buf_r && plan_r.send_en[1]) begin
              buf_nxt   = 1'b1;
              state_nxt = ST_HDR;
            end else begin
              state_nxt = ST_WR;
            end
          end
        end
      end
      ST_WR: begin
        // samples land only after every read of this request is done
        if (plan_r.wr_en[0]) begin
          ram_we            = 1'b1;
          plan_nxt.wr_en[0] = 1'b0;
          if (!plan_r.wr_en[1]) begin
            state_nxt = after_wr;
          end
        end else if (plan_r.wr_en[1]) begin
          ram_we            = 1'b1;
          ram_waddr         = waddr1_r;
          ram_wdata         = plan_r.wr_data1;
          plan_nxt.wr_en[1] = 1'b0;
          state_nxt         = after_wr;
        end else begin
          state_nxt = after_wr;
        end
      end
      ST_LED: begin
        if (out_free) begin
          res_load       = 1'b1;
          res_nxt.kind   = KIND_LED;
          res_nxt.seq    = '0;
          res_nxt.mask   = '0;
          res_nxt.mode   = '0;
          res_nxt.len    = '0;
          res_nxt.sample = '0;
          res_nxt.last   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign pend_nxt      = ram_re ? 1'b1 : ((pend_r && out_free) ? 1'b0 : pend_r);
  assign out_valid_nxt = res_load ? 1'b1 : (res_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plan_r     <= plan_nxt;
    waddr0_r   <= waddr0_nxt;
    waddr1_r   <= waddr1_nxt;
    buf_r      <= buf_nxt;
    seq_r      <= seq_nxt;
    rd_idx_r   <= rd_idx_nxt;
    emit_idx_r <= emit_idx_nxt;
    res_r      <= res_nxt;
  end

  assign res       = res_r;
  assign res_valid = out_valid_r;
  assign busy      = state_r != ST_IDLE;

  `ADCPP_ASSERT_IMPLY(a_read_only_in_data, clk, rst_n, ram_re, state_r == ST_DATA)
  `ADCPP_ASSERT_IMPLY(a_no_result_overwrite, clk, rst_n, out_valid_r && !res_ready, !res_load)
  `ADCPP_ASSERT_IMPLY(a_plan_only_when_idle, clk, rst_n, plan_valid, state_r == ST_IDLE)
  `ADCPP_ASSERT_NEXT(a_frame_leaves_data, clk, rst_n, state_r == ST_DATA && pend_r && out_free && emit_idx_r == LAST_W, state_r != ST_DATA)

endmodule

@@ rtl/core/adc_pingpong_packetizer.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Handshake           Payload
// in_      slave      tvalid/tready       tuser: func; tdata: time, conversions,
//                                         two samples, send accept flags
// out_     master     tvalid/tready/tlast tuser: kind; tdata: frame header fields
//                                         and sample
// cfg_     APB slave  psel/penable/pready interval, second channel enable, mode
//
// Start, stop, reserved codes and polls while stopped produce no plan. A running
// poll that sends buffers goes through a plan step, per frame a header and the
// sample reads from the single read port, then the sample writes and an LED result
// when it toggles.
// Reset is synchronous and clears control state only; the sample RAM is not cleared.
// A stalled out_tready holds the sequencer; in_tready stays low until the sequencer
// has loaded the last result of the request and finished its sample writes.
module adc_pingpong_packetizer #(
  parameter int BATCH_SAMPLES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] func
  input  logic [1:0]  in_tuser,
  // [31:0] now_cycles, [33:32] conversions_done, [45:34] sample_first,
  // [57:46] sample_second, [59:58] send_accept, [63:60] zero
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tlast,
  // [1:0] kind
  output logic [1:0]  out_tuser,
  // [15:0] sequence_number, [17:16] channel_mask, [25:18] mode_byte,
  // [32:26] payload_length, [44:33] sample_value, [47:45] zero
  output logic [47:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import adcpp_pkg::*;

  localparam int AW = $clog2(2*BATCH_SAMPLES);

  // configuration registers
  logic [31:0] interval_r, interval_nxt;
  logic        chan2_r, chan2_nxt;
  logic [7:0]  mode_r, mode_nxt;
  logic        cfg_wr;

  logic          in_fire, plan_valid, emit_busy;
  plan_t         plan;
  logic [AW-1:0] plan_waddr0, plan_waddr1;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [11:0]   ram_wdata, ram_rdata;
  res_t          res;

  // take a new request only when the sequencer has drained the last one
  assign in_tready = !plan_valid && !emit_busy;
  assign in_fire   = in_tvalid && in_tready;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    interval_nxt = interval_r;
    chan2_nxt    = chan2_r;
    mode_nxt     = mode_r;
    if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_INTERVAL: interval_nxt = cfg_pwdata;
        REG_CHAN2:    chan2_nxt    = cfg_pwdata[0];
        REG_MODE:     mode_nxt     = cfg_pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_INTERVAL: cfg_prdata = interval_r;
      REG_CHAN2:    cfg_prdata = {31'd0, chan2_r};
      REG_MODE:     cfg_prdata = {24'd0, mode_r};
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= '0;
      chan2_r    <= 1'b0;
      mode_r     <= '0;
    end else begin
      interval_r <= interval_nxt;
      chan2_r    <= chan2_nxt;
      mode_r     <= mode_nxt;
    end
  end

  // decode the request, update control state, plan the poll's work
  adcpp_ctrl #(
    .BATCH_SAMPLES(BATCH_SAMPLES)
  ) u_ctrl (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_fire               (in_fire),
    .func                  (in_tuser),
    .now_cycles            (in_tdata[31:0]),
    .conversions_done      (in_tdata[33:32]),
    .sample_first          (in_tdata[45:34]),
    .sample_second         (in_tdata[57:46]),
    .send_accept           (in_tdata[59:58]),
    .interval_cycles       (interval_r),
    .second_channel_enable (chan2_r),
    .frame_mode            (mode_r),
    .plan                  (plan),
    .plan_valid            (plan_valid),
    .plan_waddr0           (plan_waddr0),
    .plan_waddr1           (plan_waddr1)
  );

  // walk the plan: frames out of the RAM, then sample writes, then LED toggle
  adcpp_emit #(
    .BATCH_SAMPLES(BATCH_SAMPLES)
  ) u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .plan_valid  (plan_valid),
    .plan        (plan),
    .plan_waddr0 (plan_waddr0),
    .plan_waddr1 (plan_waddr1),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .res         (res),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .busy        (emit_busy)
  );

  // both ping-pong buffers, buffer 1 above buffer 0
  adcpp_ram #(
    .WIDTH(12),
    .DEPTH(2*BATCH_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tuser = res.kind;
  assign out_tlast = res.last;
  assign out_tdata = {3'd0, res.sample, res.len, res.mode, res.mask, res.seq};

endmodule
